// ----- sv/edu_pkg.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance unit package
// Shared widths, limits and types for the distance datapath.
// ----------------------------------------------------------------------------
package edu_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_DIMS   = 1024;

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int MAG_BITS  = COORD_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int SUM_BITS  = 42;
  localparam int DIST_BITS = 21;

  localparam logic [SUM_BITS-1:0] DIFF_MAX = SUM_BITS'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [SUM_BITS:0]   SUM_MAX  =
    (SUM_BITS+1)'(64'(MAX_DIMS) * 64'(DIFF_MAX) * 64'(DIFF_MAX));

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam int SQRT_STEPS = DIST_BITS;
  localparam int STEP_BITS  = $clog2(SQRT_STEPS);
  localparam int REM_BITS   = DIST_BITS + 3;

  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] total;
  } edu_push_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_CALC,
    BE_DONE
  } edu_be_state_t;

endpackage

// ----- sv/edu_front.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance front end
// Takes coordinate pairs, squares their difference and keeps the saturating
// running sum; the total of each vector is handed to the queue.
// ----------------------------------------------------------------------------
module edu_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [edu_pkg::COORD_BITS-1:0]  coord_a,
  input  logic signed [edu_pkg::COORD_BITS-1:0]  coord_b,
  input  logic                                   last_coord,
  input  logic [edu_pkg::QCNT_BITS-1:0]          q_count,
  output edu_pkg::edu_push_t                     q_push
);

  logic                             s1_valid;
  logic                             s1_last;
  logic [edu_pkg::MAG_BITS-1:0]     s1_mag;
  logic                             s2_valid;
  logic                             s2_last;
  logic [edu_pkg::SQ_BITS-1:0]      s2_sq;
  logic [edu_pkg::SUM_BITS-1:0]     running_sum;

  logic                             accept;
  logic signed [edu_pkg::DIFF_BITS-1:0] diff;
  logic [edu_pkg::DIFF_BITS-1:0]    diff_abs;
  logic [edu_pkg::QCNT_BITS:0]      pending;
  logic [edu_pkg::SUM_BITS:0]       sum_ext;
  logic [edu_pkg::SUM_BITS-1:0]     total;

  // Every vector end in flight already holds a queue slot.
  assign pending = {1'b0, q_count}
                 + (edu_pkg::QCNT_BITS+1)'(s1_valid & s1_last)
                 + (edu_pkg::QCNT_BITS+1)'(s2_valid & s2_last);
  assign full   = (pending >= (edu_pkg::QCNT_BITS+1)'(edu_pkg::QDEPTH));
  assign accept = push & ~full;

  assign diff     = {coord_a[edu_pkg::COORD_BITS-1], coord_a}
                  - {coord_b[edu_pkg::COORD_BITS-1], coord_b};
  assign diff_abs = diff[edu_pkg::DIFF_BITS-1] ? -diff : diff;

  assign sum_ext = {1'b0, running_sum} + (edu_pkg::SUM_BITS+1)'(s2_sq);
  assign total   = (sum_ext > edu_pkg::SUM_MAX) ? edu_pkg::SUM_MAX[edu_pkg::SUM_BITS-1:0]
                                               : sum_ext[edu_pkg::SUM_BITS-1:0];

  assign q_push.valid = s2_valid & s2_last;
  assign q_push.total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      running_sum <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        running_sum <= s2_last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_mag  <= diff_abs[edu_pkg::MAG_BITS-1:0];
    s1_last <= last_coord;
    s2_sq   <= s1_mag * s1_mag;
    s2_last <= s1_last;
  end

endmodule

// ----- sv/edu_queue.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance total queue
// Short first-in first-out store of vector totals between the two ends.
// ----------------------------------------------------------------------------
module edu_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  edu_pkg::edu_push_t                q_push,
  input  logic                              q_pop,
  output logic [edu_pkg::SUM_BITS-1:0]      q_head,
  output logic [edu_pkg::QCNT_BITS-1:0]     q_count
);

  logic [edu_pkg::SUM_BITS-1:0]  mem [edu_pkg::QDEPTH];
  logic [edu_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [edu_pkg::QPTR_BITS-1:0] rd_ptr;

  assign q_head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + edu_pkg::QCNT_BITS'(q_push.valid)
                         - edu_pkg::QCNT_BITS'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem[wr_ptr] <= q_push.total;
    end
  end

endmodule

// ----- sv/edu_sqrt.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance back end
// Takes totals from the queue, finds the floor square root one bit per cycle
// and holds each finished word in the output register until it is popped.
// ----------------------------------------------------------------------------
module edu_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [edu_pkg::SUM_BITS-1:0]      q_head,
  input  logic [edu_pkg::QCNT_BITS-1:0]     q_count,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [edu_pkg::DIST_BITS-1:0]     distance,
  output logic [edu_pkg::SUM_BITS-1:0]      sum_squares
);

  edu_pkg::edu_be_state_t state;
  edu_pkg::edu_be_state_t state_next;

  logic [edu_pkg::SUM_BITS-1:0]  operand;
  logic [edu_pkg::SUM_BITS-1:0]  sum_hold;
  logic [edu_pkg::REM_BITS-1:0]  rem;
  logic [edu_pkg::DIST_BITS-1:0] root;
  logic [edu_pkg::STEP_BITS-1:0] step;
  logic                          out_valid;

  logic                          load;
  logic                          iterate;
  logic                          publish;
  logic                          last_step;
  logic [edu_pkg::REM_BITS-1:0]  rem_sh;
  logic [edu_pkg::REM_BITS-1:0]  trial;
  logic                          fits;

  assign last_step = (step == edu_pkg::STEP_BITS'(edu_pkg::SQRT_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      edu_pkg::BE_IDLE: begin
        if (q_count != '0) begin
          state_next = edu_pkg::BE_CALC;
        end
      end
      edu_pkg::BE_CALC: begin
        if (last_step) begin
          state_next = edu_pkg::BE_DONE;
        end
      end
      edu_pkg::BE_DONE: begin
        if (!out_valid) begin
          state_next = edu_pkg::BE_IDLE;
        end
      end
      default: state_next = edu_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    iterate = 1'b0;
    publish = 1'b0;
    case (state)
      edu_pkg::BE_IDLE: load    = (q_count != '0);
      edu_pkg::BE_CALC: iterate = 1'b1;
      edu_pkg::BE_DONE: publish = !out_valid;
      default: ;
    endcase
  end

  assign q_pop = load;

  assign rem_sh = {rem[edu_pkg::REM_BITS-3:0],
                   operand[edu_pkg::SUM_BITS-1:edu_pkg::SUM_BITS-2]};
  assign trial  = edu_pkg::REM_BITS'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= edu_pkg::BE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      operand  <= q_head;
      sum_hold <= q_head;
      rem      <= '0;
      root     <= '0;
      step     <= '0;
    end else if (iterate) begin
      operand <= {operand[edu_pkg::SUM_BITS-3:0], 2'b00};
      rem     <= fits ? rem_sh - trial : rem_sh;
      root    <= {root[edu_pkg::DIST_BITS-2:0], fits};
      step    <= step + 1'b1;
    end
    if (publish) begin
      distance    <= root;
      sum_squares <= sum_hold;
    end
  end

  assign empty = ~out_valid;

endmodule

// ----- sv/euclidean_distance_unit.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance unit
// Streams coordinate pairs and returns the floor Euclidean distance per
// vector together with the saturated sum of squared differences.
// ----------------------------------------------------------------------------
// Usage: write one coordinate pair per word with push while full is low; set
// last_coord on the final pair of a vector. Each vector yields one result
// word, read with pop while empty is low; distance and sum_squares stay put
// until popped. Pairs that are not last yield nothing.
// The front end takes one pair per cycle, while full is low, through a
// three-stage subtract, square and accumulate pipeline; vector totals wait
// in a four-entry queue. The back end loads a total in its idle state, finds
// one root bit per cycle in its calc state and publishes in its done state;
// it takes the next total only once the previous word is published. full
// rises when the queue and the pipeline hold four vector ends; a stalled
// reader thus stalls the writer only after six vectors: one in the output
// register, one finished in the back end and four in the queue.
// Reset clears the running sum and the queue and empties the output register.
// ----------------------------------------------------------------------------
module euclidean_distance_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [edu_pkg::COORD_BITS-1:0] coord_a,
  input  logic signed [edu_pkg::COORD_BITS-1:0] coord_b,
  input  logic                                  last_coord,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [edu_pkg::DIST_BITS-1:0]         distance,
  output logic [edu_pkg::SUM_BITS-1:0]          sum_squares
);

  edu_pkg::edu_push_t              q_push;
  logic                            q_pop;
  logic [edu_pkg::SUM_BITS-1:0]    q_head;
  logic [edu_pkg::QCNT_BITS-1:0]   q_count;

  edu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .coord_a    (coord_a),
    .coord_b    (coord_b),
    .last_coord (last_coord),
    .q_count    (q_count),
    .q_push     (q_push)
  );

  edu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_count (q_count)
  );

  edu_sqrt u_sqrt (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_count     (q_count),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .distance    (distance),
    .sum_squares (sum_squares)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> (q_count < edu_pkg::QCNT_BITS'(edu_pkg::QDEPTH)) || q_pop)
    else $error("total queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("total queue underflow");

  a_root_low: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (64'(distance) * 64'(distance) <= 64'(sum_squares)))
    else $error("distance too large for its sum");

  a_root_high: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((64'(distance) + 64'd1) * (64'(distance) + 64'd1) > 64'(sum_squares)))
    else $error("distance too small for its sum");

endmodule

// ----- dv/tb_euclidean_distance_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean distance unit testbench
// Streams coordinate pairs into the unit with random gaps and back-pressure,
// predicts each vector's floor distance and saturated sum of squares, and
// checks every result word in order against that prediction.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_unit;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum int {
    CRD_FULL,
    CRD_EXTREME,
    CRD_NEAR_ZERO
  } coord_style_t;

  typedef struct packed {
    logic [edu_pkg::DIST_BITS-1:0] norm;
    logic [edu_pkg::SUM_BITS-1:0]  ssq;
  } dist_word_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  push = 1'b0;
  logic                                  full;
  logic signed [edu_pkg::COORD_BITS-1:0] coord_a = '0;
  logic signed [edu_pkg::COORD_BITS-1:0] coord_b = '0;
  logic                                  last_coord = 1'b0;
  logic                                  empty;
  logic                                  pop = 1'b0;
  logic [edu_pkg::DIST_BITS-1:0]         distance;
  logic [edu_pkg::SUM_BITS-1:0]          sum_squares;

  logic [edu_pkg::SUM_BITS-1:0] vector_sum = '0;
  dist_word_t                   expected_q[$];
  dist_word_t                   head_word;
  int                           errors = 0;
  int                           items_sent = 0;
  int                           idle_cycles = 0;
  int                           stall_left = 0;
  bit                           tx_gaps = 1'b1;
  bit                           rx_stalls = 1'b1;
  bit                           rx_hold = 1'b0;

  euclidean_distance_unit uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .coord_a     (coord_a),
    .coord_b     (coord_b),
    .last_coord  (last_coord),
    .empty       (empty),
    .pop         (pop),
    .distance    (distance),
    .sum_squares (sum_squares)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [edu_pkg::DIST_BITS-1:0] floor_root(
      logic [edu_pkg::SUM_BITS-1:0] n);
    logic [edu_pkg::DIST_BITS-1:0] root;
    logic [edu_pkg::DIST_BITS-1:0] cand;
    logic [63:0]                   trial;
    root = '0;
    for (int i = edu_pkg::DIST_BITS - 1; i >= 0; i--) begin
      cand  = root | (edu_pkg::DIST_BITS'(1) << i);
      trial = 64'(cand);
      if (trial * trial <= 64'(n)) root = cand;
    end
    return root;
  endfunction

  function automatic void predict_pair(logic signed [edu_pkg::COORD_BITS-1:0] a,
                                       logic signed [edu_pkg::COORD_BITS-1:0] b,
                                       logic last);
    logic signed [edu_pkg::COORD_BITS:0] diff;
    logic [edu_pkg::COORD_BITS-1:0]      mag;
    logic [2*edu_pkg::COORD_BITS-1:0]    sq;
    logic [edu_pkg::SUM_BITS+1:0]        total;
    dist_word_t                          w;
    diff  = {a[edu_pkg::COORD_BITS-1], a} - {b[edu_pkg::COORD_BITS-1], b};
    mag   = diff[edu_pkg::COORD_BITS] ? edu_pkg::COORD_BITS'(-diff)
                                      : diff[edu_pkg::COORD_BITS-1:0];
    sq    = (2*edu_pkg::COORD_BITS)'(mag) * (2*edu_pkg::COORD_BITS)'(mag);
    total = (edu_pkg::SUM_BITS+2)'(vector_sum) + (edu_pkg::SUM_BITS+2)'(sq);
    if (total > (edu_pkg::SUM_BITS+2)'(edu_pkg::SUM_MAX)) begin
      total = (edu_pkg::SUM_BITS+2)'(edu_pkg::SUM_MAX);
    end
    if (!last) begin
      vector_sum = total[edu_pkg::SUM_BITS-1:0];
    end else begin
      w.ssq  = total[edu_pkg::SUM_BITS-1:0];
      w.norm = floor_root(w.ssq);
      expected_q.push_back(w);
      vector_sum = '0;
    end
  endfunction

  function automatic logic signed [edu_pkg::COORD_BITS-1:0] rand_coord(
      coord_style_t style);
    int v;
    case (style)
      CRD_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh8001;
          3: return -16'sd1;
          4: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      CRD_NEAR_ZERO: begin
        v = int'($urandom_range(0, 200)) - 100;
        return v[edu_pkg::COORD_BITS-1:0];
      end
      default: return edu_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_pair(logic signed [edu_pkg::COORD_BITS-1:0] a,
                           logic signed [edu_pkg::COORD_BITS-1:0] b,
                           logic last);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    coord_a    <= a;
    coord_b    <= b;
    last_coord <= last;
    do @(posedge clk); while (full);
    predict_pair(a, b, last);
    items_sent++;
  endtask

  task automatic send_vector(int len, coord_style_t style);
    for (int i = 0; i < len; i++) begin
      send_pair(rand_coord(style), rand_coord(style), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd4, 1'b1);
    send_pair(16'sd2, 16'sd0, 1'b0);
    send_pair(16'sd1, 16'sd0, 1'b1);
    repeat (3) send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd100, -16'sd100, 1'b0);
    send_pair(-16'sd7, 16'sd8, 1'b0);
    send_pair(16'sd12345, -16'sd54, 1'b1);
    wait_drained();
  endtask

  // Hold the reader until the unit reports full, then let it go.
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    rx_hold   = 1'b1;
    fork
      begin
        do @(posedge clk); while (!full);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 10; i++) send_vector(1, CRD_FULL);
    rx_hold = 1'b0;
    for (int i = 0; i < 30; i++) send_vector($urandom_range(1, 3), CRD_FULL);
    wait_drained();
  endtask

  // The sum reaches its maximum exactly on the MAX_DIMS-th full-size pair, and
  // the extra full-size pair after it must clamp.
  task automatic test_saturation();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    for (int i = 0; i <= edu_pkg::MAX_DIMS; i++) begin
      if (i[0]) send_pair(16'sh8000, 16'sh7fff, i == edu_pkg::MAX_DIMS);
      else send_pair(16'sh7fff, 16'sh8000, i == edu_pkg::MAX_DIMS);
    end
    send_pair(16'sd5, 16'sd2, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int           r;
    int           len;
    bit           paused;
    coord_style_t style;
    paused = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) tx_gaps = ~tx_gaps;
      if ($urandom_range(0, 19) == 0) rx_stalls = ~rx_stalls;
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(100, 300);
      r = $urandom_range(0, 99);
      if (r < 60) style = CRD_FULL;
      else if (r < 85) style = CRD_EXTREME;
      else style = CRD_NEAR_ZERO;
      send_vector(len, style);
      if (!paused && items_sent > RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual distance %0d sum %0d",
                   $time, distance, sum_squares);
        end else begin
          head_word = expected_q.pop_front();
          if (distance !== head_word.norm) begin
            errors++;
            $display("%0t: distance mismatch, expected %0d, actual %0d",
                     $time, head_word.norm, distance);
          end
          if (sum_squares !== head_word.ssq) begin
            errors++;
            $display("%0t: sum_squares mismatch, expected %0d, actual %0d",
                     $time, head_word.ssq, sum_squares);
          end
        end
      end
      if (rx_hold) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        stall_left = rx_stalls ? pick_gap() : 0;
        pop <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_saturation();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
